// File: hdl/gts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_pkg
// shared types, microcode format and microcode program of the gcd token
// similarity unit
// ----------------------------------------------------------------------------
package gts_pkg;

  localparam int TOKEN_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int STEP_BITS = 3;
  typedef logic [STEP_BITS-1:0] step_t;

  // program addresses
  localparam step_t S_IDLE     = 3'd0;
  localparam step_t S_CHECK    = 3'd1;
  localparam step_t S_GCD      = 3'd2;
  localparam step_t S_DIV_INIT = 3'd3;
  localparam step_t S_DIV      = 3'd4;
  localparam step_t S_OUT      = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD,
    OP_DIV_INIT,
    OP_DIV,
    OP_OUT
  } op_t;

  // jump taken when the condition holds, otherwise fall through
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NSTART,
    C_ZERO,
    C_NEQ,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic zero;  // either token is zero
    logic neq;   // gcd operands still differ
    logic more;  // division bits left after this one
  } dp_flags_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      S_IDLE:     w = '{op: OP_LOAD,     cond: C_NSTART, target: S_IDLE};
      S_CHECK:    w = '{op: OP_NOP,      cond: C_ZERO,   target: S_OUT};
      S_GCD:      w = '{op: OP_GCD,      cond: C_NEQ,    target: S_GCD};
      S_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEVER,  target: S_IDLE};
      S_DIV:      w = '{op: OP_DIV,      cond: C_MORE,   target: S_DIV};
      S_OUT:      w = '{op: OP_OUT,      cond: C_ALWAYS, target: S_IDLE};
      default:    w = '{op: OP_NOP,      cond: C_ALWAYS, target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/gcd_token_similarity_unit.sv
`timescale 1ns / 1ps
// sequence: when either token is zero the check step goes straight to the
//   output step; otherwise the binary gcd loop runs until the operands meet,
//   then the divider yields FRACTION_BITS + 1 quotient bits before output
// throughput: one request at a time; busy drops in the cycle done is shown
// reset: synchronous rst returns the step counter to idle and clears done
// ----------------------------------------------------------------------------
// gcd_token_similarity_unit
// gcd of two token ids plus one, and that gcd over the larger id plus one
// as an unsigned Q1.FRACTION_BITS fraction
// ----------------------------------------------------------------------------
module gcd_token_similarity_unit
  import gts_pkg::*;
#(
  parameter int TOKEN_BITS    = TOKEN_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [TOKEN_BITS-1:0]  token_a,
  input  logic [TOKEN_BITS-1:0]  token_b,
  output logic                   done,
  output logic [FRACTION_BITS:0] similarity,
  output logic [TOKEN_BITS:0]    common_divisor
);

  // control word from the microcode rom, flags back from the datapath
  ucode_t    ctl;
  dp_flags_t flags;

  // step counter and program rom; idle step loads the operands every cycle
  // and leaves idle on start
  gts_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  // binary gcd: shift out common twos, then subtract and halve odd values
  // until both operands meet; the gcd is the result shifted back up,
  // followed by one quotient bit per cycle of the restoring divider
  gts_datapath #(
    .TOKEN_BITS    (TOKEN_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .token_a        (token_a),
    .token_b        (token_b),
    .flags          (flags),
    .done           (done),
    .similarity     (similarity),
    .common_divisor (common_divisor)
  );

endmodule

// File: hdl/gts_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_sequencer
// step counter over the microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module gts_sequencer
  import gts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_flags_t flags,
  output ucode_t    ctl,
  output logic      busy
);

  step_t step;
  step_t step_next;
  logic  take;

  assign ctl  = ucode_rom(step);
  assign busy = (step != S_IDLE);

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_NSTART: take = ~start;
      C_ZERO:   take = flags.zero;
      C_NEQ:    take = flags.neq;
      C_MORE:   take = flags.more;
      default:  take = 1'b1;
    endcase
    step_next = take ? ctl.target : step + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: hdl/gts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_datapath
// binary gcd registers and a restoring divider, driven by the control word
// ----------------------------------------------------------------------------
module gts_datapath
  import gts_pkg::*;
#(
  parameter int TOKEN_BITS    = TOKEN_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ucode_t                   ctl,
  input  logic [TOKEN_BITS-1:0]    token_a,
  input  logic [TOKEN_BITS-1:0]    token_b,
  output dp_flags_t                flags,
  output logic                     done,
  output logic [FRACTION_BITS:0]   similarity,
  output logic [TOKEN_BITS:0]      common_divisor
);

  localparam int DW = TOKEN_BITS + 1;
  localparam int KW = $clog2(TOKEN_BITS + 1);
  localparam int QW = FRACTION_BITS + 1;
  localparam int CW = $clog2(FRACTION_BITS + 2);

  logic [DW-1:0] x;
  logic [DW-1:0] y;
  logic [KW-1:0] k;
  logic [DW-1:0] top;
  logic          zero;
  logic [DW-1:0] gcd;
  logic [DW:0]   rem;
  logic [QW-1:0] quo;
  logic [CW-1:0] cnt;

  logic          x_gt_y;
  logic [DW-1:0] diff;
  logic          ge;
  logic [DW:0]   rem_sub;

  assign x_gt_y  = (x > y);
  assign diff    = x_gt_y ? (x - y) : (y - x);
  assign ge      = (rem >= {1'b0, top});
  assign rem_sub = ge ? (rem - {1'b0, top}) : rem;

  assign flags.zero = zero;
  assign flags.neq  = (x != y);
  assign flags.more = (cnt != CW'(1));

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        x    <= {1'b0, token_a} + DW'(1);
        y    <= {1'b0, token_b} + DW'(1);
        k    <= '0;
        top  <= ((token_a > token_b) ? {1'b0, token_a} : {1'b0, token_b}) + DW'(1);
        zero <= (token_a == '0) || (token_b == '0);
      end
      OP_GCD: begin
        if (x != y) begin
          priority if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + KW'(1);
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x_gt_y) begin
            x <= diff >> 1;
          end else begin
            y <= diff >> 1;
          end
        end
      end
      OP_DIV_INIT: begin
        gcd <= DW'(x << k);
        rem <= {1'b0, DW'(x << k)};
        quo <= '0;
        cnt <= CW'(QW);
      end
      OP_DIV: begin
        quo <= {quo[QW-2:0], ge};
        rem <= {rem_sub[DW-1:0], 1'b0};
        cnt <= cnt - CW'(1);
      end
      OP_OUT: begin
        similarity     <= zero ? '0 : quo;
        common_divisor <= zero ? '0 : gcd;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctl.op == OP_OUT);
    end
  end

endmodule

// File: hdl/gts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_checker
// port-level checks of the gcd token similarity unit
// ----------------------------------------------------------------------------
module gts_checker
  import gts_pkg::*;
#(
  parameter int TOKEN_BITS    = TOKEN_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [FRACTION_BITS:0] similarity,
  input logic [TOKEN_BITS:0]    common_divisor
);

  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_zero_pair: assert property (@(posedge clk) disable iff (rst)
    done && (common_divisor == '0) |-> (similarity == '0))
    else $error("zero divisor with nonzero similarity");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (similarity <= ONE))
    else $error("similarity above one");

endmodule

bind gcd_token_similarity_unit gts_checker #(
  .TOKEN_BITS    (TOKEN_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_gts_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .similarity     (similarity),
  .common_divisor (common_divisor)
);

// File: verif/gcd_token_similarity_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_token_similarity_unit_tb
// drives token pairs into the gcd similarity unit and checks every result
// against a predictor of the euclidean gcd of both tokens plus one and its
// truncated Q1.16 ratio to the larger token plus one; directed corner
// pairs come first, then shaped random pairs with bursty request traffic
// ----------------------------------------------------------------------------
module gcd_token_similarity_unit_tb;
  import gts_pkg::*;

  localparam int TB_TOKEN_BITS = TOKEN_BITS_DEF;
  localparam int TB_FRAC_BITS  = FRACTION_BITS_DEF;
  localparam int TOKEN_MAX     = (1 << TB_TOKEN_BITS) - 1;
  localparam int QUIET_LIMIT   = 4000;  // cycles with no request or result
  localparam int SETTLE_CYCLES = 200;   // well past the worst-case latency
  localparam int RANDOM_PAIRS  = 610;

  typedef logic [TB_TOKEN_BITS-1:0] token_t;

  typedef struct {
    logic [TB_FRAC_BITS:0]  similarity;
    logic [TB_TOKEN_BITS:0] common_divisor;
    token_t                 token_a;
    token_t                 token_b;
  } score_t;

  // shapes of random token pairs
  typedef enum int {
    PAIR_UNIFORM,
    PAIR_SMALL,
    PAIR_SHARED_FACTOR,
    PAIR_FIBONACCI,
    PAIR_EQUAL,
    PAIR_ZERO,
    PAIR_EXTREME,
    PAIR_KINDS
  } pair_kind_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  token_t token_a;
  token_t token_b;
  logic   done;
  logic [TB_FRAC_BITS:0]  similarity;
  logic [TB_TOKEN_BITS:0] common_divisor;

  score_t expected_scores[$];
  int     error_count;
  int     quiet_cycles;

  gcd_token_similarity_unit dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .token_a        (token_a),
    .token_b        (token_b),
    .done           (done),
    .similarity     (similarity),
    .common_divisor (common_divisor)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // euclid on the tokens plus one, then the ratio to the larger token plus one
  function automatic score_t predict_score(input token_t a, input token_t b);
    score_t          s;
    longint unsigned x;
    longint unsigned y;
    longint unsigned r;
    longint unsigned top;
    s.token_a = a;
    s.token_b = b;
    if (a == '0 || b == '0) begin
      s.similarity     = '0;
      s.common_divisor = '0;
    end else begin
      x = longint'(a) + 1;
      y = longint'(b) + 1;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      top              = ((a > b) ? longint'(a) : longint'(b)) + 1;
      s.similarity     = (TB_FRAC_BITS+1)'((x << TB_FRAC_BITS) / top);
      s.common_divisor = (TB_TOKEN_BITS+1)'(x);
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // drive one request at the falling edge and hold it until it is taken;
  // start stays high afterwards so the next request can follow at once
  task automatic send_tokens(input token_t a, input token_t b);
    @(negedge clk);
    start   = 1'b1;
    token_a = a;
    token_b = b;
    do @(posedge clk); while (busy);
    expected_scores.push_back(predict_score(a, b));
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off new requests until every outstanding result is back
  task automatic drain_results();
    idle_for(0);
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // results are strobed for one cycle; the receiver never stalls
  always @(posedge clk) begin : check_results
    score_t want;
    if (!rst && done) begin
      if (expected_scores.size() == 0) begin
        report_mismatch($sformatf("unexpected result sim=%0d gcd=%0d",
                                  similarity, common_divisor));
      end else begin
        want = expected_scores.pop_front();
        if (similarity !== want.similarity)
          report_mismatch($sformatf("a=%0d b=%0d similarity %0d, want %0d",
                                    want.token_a, want.token_b,
                                    similarity, want.similarity));
        if (common_divisor !== want.common_divisor)
          report_mismatch($sformatf("a=%0d b=%0d common_divisor %0d, want %0d",
                                    want.token_a, want.token_b,
                                    common_divisor, want.common_divisor));
      end
    end
  end

  // watchdog on cycles in which neither a request nor a result moves
  always @(posedge clk) begin : watchdog
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // either token zero forces both results to zero
  task automatic test_zero_tokens();
    send_tokens('0, '0);
    send_tokens('0, token_t'(TOKEN_MAX));
    send_tokens(token_t'(TOKEN_MAX), '0);
    send_tokens('0, token_t'(1));
    send_tokens(token_t'(12345), '0);
    drain_results();
  endtask

  // equal tokens give exactly one point zero and the token plus one
  task automatic test_equal_tokens();
    send_tokens(token_t'(1), token_t'(1));
    send_tokens(token_t'(TOKEN_MAX), token_t'(TOKEN_MAX));
    send_tokens(token_t'(24'h800000), token_t'(24'h800000));
    send_tokens(token_t'(24'h555555), token_t'(24'haaaaaa - 24'h555555));
    drain_results();
  endtask

  // extremes of the fields, coprime pairs, long euclid chains
  task automatic test_field_extremes();
    send_tokens(token_t'(1), token_t'(TOKEN_MAX));
    send_tokens(token_t'(TOKEN_MAX), token_t'(1));
    send_tokens(token_t'(1), token_t'(2));
    send_tokens(token_t'(TOKEN_MAX - 1), token_t'(TOKEN_MAX));
    send_tokens(token_t'(24'h7fffff), token_t'(TOKEN_MAX));
    send_tokens(token_t'(24'haaaaaa), token_t'(24'h555555));
    send_tokens(token_t'(24'h3fffff), token_t'(24'hbfffff));
    send_tokens(token_t'(14930351), token_t'(9227464));   // fibonacci minus one
    send_tokens(token_t'(3), token_t'(TOKEN_MAX));
    send_tokens(token_t'(24'h000fff), token_t'(24'hffefff));
    drain_results();
  endtask

  // mostly structured pairs so the gcd is often nontrivial, plus noise
  task automatic test_random_pairs();
    int         burst_left;
    int         fib_a;
    int         fib_b;
    int         fib_c;
    int         steps;
    int         factor;
    pair_kind_t kind;
    token_t     a;
    token_t     b;
    burst_left = 0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      kind = pair_kind_t'($urandom_range(0, PAIR_KINDS - 1));
      unique case (kind)
        PAIR_UNIFORM: begin
          a = token_t'($urandom());
          b = token_t'($urandom());
        end
        PAIR_SMALL: begin
          a = token_t'($urandom_range(1, 300));
          b = token_t'($urandom_range(1, 300));
        end
        PAIR_SHARED_FACTOR: begin
          factor = $urandom_range(2, 65536);
          a = token_t'(factor * $urandom_range(1, (TOKEN_MAX + 1) / factor) - 1);
          b = token_t'(factor * $urandom_range(1, (TOKEN_MAX + 1) / factor) - 1);
        end
        PAIR_FIBONACCI: begin
          // consecutive fibonacci numbers give the longest euclid chains
          fib_a = 1;
          fib_b = 2;
          steps = $urandom_range(1, 33);
          for (int k = 0; k < steps; k++) begin
            fib_c = fib_a + fib_b;
            fib_a = fib_b;
            fib_b = fib_c;
          end
          a = token_t'(fib_b - 1);
          b = token_t'(fib_a - 1);
          if ($urandom_range(0, 1)) begin
            a = token_t'(fib_a - 1);
            b = token_t'(fib_b - 1);
          end
        end
        PAIR_EQUAL: begin
          a = token_t'($urandom());
          b = a;
        end
        PAIR_ZERO: begin
          a = $urandom_range(0, 1) ? '0 : token_t'($urandom());
          b = (a == '0) ? token_t'($urandom()) : '0;
        end
        default: begin
          a = $urandom_range(0, 1) ? token_t'(TOKEN_MAX) : token_t'(1);
          b = $urandom_range(0, 1) ? token_t'(TOKEN_MAX - $urandom_range(0, 3))
                                   : token_t'($urandom_range(1, 4));
        end
      endcase

      // bursts with random gaps, except for one stretch at full rate
      if (burst_left == 0) begin
        if (i < 150 || i >= 250)
          idle_for($urandom_range(0, 1) ? $urandom_range(0, 3)
                                        : $urandom_range(4, 30));
        burst_left = $urandom_range(1, 20);
      end
      send_tokens(a, b);
      burst_left--;

      if (i == RANDOM_PAIRS / 2)
        drain_results();
    end
    idle_for(0);
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    token_a      = '0;
    token_b      = '0;
    error_count  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_tokens();
    test_equal_tokens();
    test_field_extremes();
    test_random_pairs();

    // wait for the last results, then let the unit settle
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
